>>> sv/tlcr_pkg.sv
// Package for the text line cell renderer: sizes, character codes, register
// indexes and the command and status structs between controller and datapath.
// Depends on nothing.
package tlcr_pkg;

   // Screen geometry and field widths.
   localparam int ROWS     = 32;
   localparam int MAX_COLS = 128;
   localparam int ROW_W    = $clog2(ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int DEPTH    = ROWS * MAX_COLS;
   localparam int CELL_W   = 8;
   localparam int SRC_W    = 12;
   localparam int TAB_W    = 5;
   localparam int LEN_W    = 8;
   localparam int CNT_W    = 5;
   localparam int MODC_W   = $clog2(SRC_W);

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_DATA_W = 8;

   // Register reset values and limits.
   localparam logic [TAB_W-1:0] TAB_RESET  = 5'd8;
   localparam logic [TAB_W-1:0] TAB_MAX    = 5'd16;
   localparam logic [LEN_W-1:0] LINE_RESET = 8'd80;
   localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_COLS);

   // Character codes.
   localparam logic [CELL_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CELL_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CELL_W-1:0] CH_DEL    = 8'h7F;
   localparam logic [CELL_W-1:0] CH_AT     = 8'h40;
   localparam logic [CELL_W-1:0] CH_CARET  = 8'h5E;
   localparam logic [CELL_W-1:0] CH_BANG   = 8'h21;
   localparam logic [CELL_W-1:0] CH_GT     = 8'h3E;
   localparam logic [CELL_W-1:0] CH_UNDER  = 8'h5F;
   localparam logic [CELL_W-1:0] CH_QUEST  = 8'h3F;
   localparam logic [CELL_W-1:0] CH_FF     = 8'hFF;
   localparam logic [CELL_W-1:0] CH_ONE    = 8'h01;

   // Request kinds carried in req_tuser.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_CHAR  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_TAB_WIDTH  = 1'b0,
      CSR_LINE_CELLS = 1'b1
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic load_start;
      logic load_char;
      logic mod_step;
      logic skip_apply;
      logic seq_begin;
      logic rd_issue;
      logic cell_put;
      logic flush;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic line_done;
      logic req_tab;
      logic mod_last;
      logic skipping;
      logic emit;
      logic hold_valid;
      logic out_free;
      logic seq_end;
   } dp_status_type;

endpackage

>>> sv/tlcr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tlcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tlcr_ctrl.sv
// Controller state machine of the text line cell renderer: sequences the
// clearing pass, request decode, tab remainder, per-cell read and compare, and flush.
// Depends on tlcr_pkg.
module tlcr_ctrl
   import tlcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_func,
   output logic          req_tready,
   input  dp_status_type st,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_DECIDE,
      S_READ,
      S_CMP,
      S_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_func == FUNC_START) begin
                  cmd.load_start = 1'b1;
               end else if (!st.line_done) begin
                  cmd.load_char = 1'b1;
                  state_in      = st.req_tab ? S_MOD : S_DECIDE;
               end
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (st.mod_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (st.skipping) begin
               cmd.skip_apply = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.seq_begin = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_CMP;
         end
         S_CMP: begin
            // A new cell that must be shown waits while the pending one cannot move out.
            if (!(st.emit && st.hold_valid && !st.out_free)) begin
               cmd.cell_put = 1'b1;
               state_in     = st.seq_end ? S_FLUSH : S_READ;
            end
         end
         S_FLUSH: begin
            if (!st.hold_valid) begin
               state_in = S_IDLE;
            end else if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/tlcr_dp.sv
// Datapath of the text line cell renderer: configuration, line state, tab
// remainder unit, cell expansion, cell memory, pending cell and output register.
// Depends on tlcr_pkg and tlcr_ram.
module tlcr_dp
   import tlcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request fields
   input  logic [ROW_W-1:0]      req_row,
   input  logic [COL_W-1:0]      req_screen_col,
   input  logic [SRC_W-1:0]      req_skip_cols,
   input  logic                  req_text_mode,
   input  logic                  req_inverse,
   input  logic                  req_show_space,
   input  logic [CELL_W-1:0]     req_char_code,
   input  logic                  req_is_last,
   // Configuration port
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // Controller link
   input  ctrl_cmd_type          cmd,
   output dp_status_type         st,
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ROW_W-1:0]      rsp_row,
   output logic [COL_W-1:0]      rsp_col,
   output logic [CELL_W-1:0]     rsp_char,
   output logic                  rsp_move,
   output logic                  rsp_last
);

   // Configuration registers.
   logic [TAB_W-1:0]  tab_width_ff;
   logic [LEN_W-1:0]  line_cells_ff;

   // Line state.
   logic [ROW_W-1:0]  cur_row_ff;
   logic [COL_W-1:0]  cur_col_ff;
   logic [LEN_W-1:0]  cells_left_ff;
   logic [SRC_W-1:0]  src_col_ff;
   logic [SRC_W-1:0]  skip_goal_ff;
   logic              skipping_ff;
   logic              inv_ff;
   logic              show_ff;
   logic              line_done_ff;
   logic [ROW_W-1:0]  term_row_ff;
   logic [COL_W:0]    term_col_ff;

   // Current character.
   logic [CELL_W-1:0] ch_ff;
   logic              last_ff;
   logic              tab_ff;
   logic              ctl_ff;
   logic [TAB_W-2:0]  rem_ff;
   logic [MODC_W-1:0] mod_cnt_ff;
   logic [CNT_W-1:0]  k_ff;
   logic [CNT_W-1:0]  m_ff;
   logic [CELL_W-1:0] cell_ch_ff;
   logic              cell_broke_ff;

   // Clearing pass.
   logic [ADDR_W-1:0] clr_ff;

   // Pending cell and output register.
   logic              hold_valid_ff;
   logic [ROW_W-1:0]  hold_row_ff;
   logic [COL_W-1:0]  hold_col_ff;
   logic [CELL_W-1:0] hold_char_ff;
   logic              hold_move_ff;
   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [CELL_W-1:0] rsp_char_ff;
   logic              rsp_move_ff;
   logic              rsp_last_ff;

   // Combinational terms.
   logic [TAB_W-1:0]  tw;
   logic [LEN_W-1:0]  len;
   logic [LEN_W:0]    room;
   logic              room_pos;
   logic [SRC_W-1:0]  start_src;
   logic [SRC_W-1:0]  start_goal;
   logic [TAB_W-1:0]  rem_shift;
   logic [TAB_W-2:0]  rem_next;
   logic [CNT_W-1:0]  adv;
   logic [SRC_W:0]    skip_sum;
   logic [CELL_W-1:0] plain_ch;
   logic [CELL_W-1:0] seq_ch;
   logic              broke_now;
   logic [ADDR_W-1:0] cell_addr;
   logic [CELL_W-1:0] mem_rd;
   logic              emit;
   logic              move;
   logic              push_mid;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;

   assign csr_ready = 1'b1;

   // Effective tab width and line length.
   always_comb begin
      priority if (tab_width_ff == '0) begin
         tw = TAB_W'(1);
      end else if (tab_width_ff > TAB_MAX) begin
         tw = TAB_MAX;
      end else begin
         tw = tab_width_ff;
      end
   end

   assign len = (line_cells_ff > LEN_MAX) ? LEN_MAX : line_cells_ff;

   // Cells available after the start column, as a signed difference.
   assign room       = {1'b0, len} - (LEN_W+1)'(1) - (LEN_W+1)'(req_screen_col);
   assign room_pos   = !room[LEN_W] && (room != '0);
   assign start_src  = req_text_mode ? SRC_W'(req_screen_col) : '0;
   assign start_goal = req_text_mode ? '0 : req_skip_cols;

   // One step of the restoring remainder of the source column by the tab width.
   assign rem_shift = {rem_ff, src_col_ff[mod_cnt_ff]};
   assign rem_next  = (rem_shift >= tw) ? (TAB_W-1)'(rem_shift - tw)
                                        : rem_shift[TAB_W-2:0];

   // Columns the character advances in the source.
   always_comb begin
      priority if (tab_ff) begin
         adv = tw - {1'b0, rem_ff};
      end else if (ctl_ff) begin
         adv = CNT_W'(2);
      end else begin
         adv = CNT_W'(1);
      end
   end

   assign skip_sum = {1'b0, src_col_ff} + (SRC_W+1)'(adv);

   // Display code for a plain character.
   always_comb begin
      plain_ch = (ch_ff == CH_FF) ? CH_ONE : ch_ff;
      if (plain_ch == CH_SPACE) begin
         if (show_ff) begin
            plain_ch = CH_UNDER;
         end else if (inv_ff) begin
            plain_ch = CH_FF;
         end
      end
   end

   // Cell k of the expansion.
   always_comb begin
      priority if (tab_ff) begin
         seq_ch = (k_ff == '0 && show_ff) ? CH_GT : CH_SPACE;
      end else if (ctl_ff) begin
         if (k_ff == '0) begin
            seq_ch = CH_CARET;
         end else begin
            seq_ch = (ch_ff == CH_DEL) ? CH_QUEST : ch_ff + CH_AT;
         end
      end else begin
         seq_ch = plain_ch;
      end
   end

   // The line runs out when this cell uses the last count.
   assign broke_now = (cells_left_ff == LEN_W'(1));
   assign cell_addr = {cur_row_ff, cur_col_ff};

   // Compare against the stored cell and check the terminal cursor.
   assign emit     = inv_ff || (mem_rd != cell_ch_ff);
   assign move     = (cur_row_ff != term_row_ff) || ({1'b0, cur_col_ff} != term_col_ff);
   assign push_mid = cmd.cell_put && emit && hold_valid_ff;

   // Memory write port: clearing pass or a shown cell.
   assign ram_wr_en   = cmd.clr_step || (cmd.cell_put && emit);
   assign ram_wr_addr = cmd.clr_step ? clr_ff : cell_addr;
   assign ram_wr_data = cmd.clr_step ? CH_SPACE : cell_ch_ff;

   tlcr_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (cell_addr),
      .rd_data (mem_rd)
   );

   // Status to the controller.
   always_comb begin
      st.clr_last   = (clr_ff == '1);
      st.line_done  = line_done_ff;
      st.req_tab    = (req_char_code == CH_TAB);
      st.mod_last   = (mod_cnt_ff == '0);
      st.skipping   = skipping_ff;
      st.emit       = emit;
      st.hold_valid = hold_valid_ff;
      st.out_free   = !rsp_valid_ff || rsp_tready;
      st.seq_end    = cell_broke_ff || (({1'b0, k_ff} + (CNT_W+1)'(1)) >= {1'b0, m_ff});
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff  <= TAB_RESET;
         line_cells_ff <= LINE_RESET;
         clr_ff        <= '0;
         line_done_ff  <= 1'b1;
         skipping_ff   <= 1'b0;
         cells_left_ff <= '0;
         term_row_ff   <= '0;
         term_col_ff   <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Configuration writes.
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TAB_WIDTH:  tab_width_ff  <= csr_data[TAB_W-1:0];
               CSR_LINE_CELLS: line_cells_ff <= csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         // Start of a line write.
         if (cmd.load_start) begin
            cells_left_ff <= room_pos ? room[LEN_W-1:0] : '0;
            line_done_ff  <= !room_pos;
            skipping_ff   <= (start_src < start_goal);
         end
         // Consumed without output while horizontally scrolled.
         if (cmd.skip_apply) begin
            if (skip_sum >= {1'b0, skip_goal_ff}) begin
               skipping_ff <= 1'b0;
            end
            if (last_ff) begin
               line_done_ff <= 1'b1;
            end
         end
         if (cmd.rd_issue) begin
            cells_left_ff <= cells_left_ff - LEN_W'(1);
         end
         // Cell put: update the terminal cursor and pending cell.
         if (cmd.cell_put) begin
            if (emit) begin
               term_row_ff   <= cur_row_ff;
               term_col_ff   <= {1'b0, cur_col_ff} + (COL_W+1)'(1);
               hold_valid_ff <= 1'b1;
            end
            if (st.seq_end && (last_ff || cell_broke_ff)) begin
               line_done_ff <= 1'b1;
            end
         end else if (cmd.flush) begin
            hold_valid_ff <= 1'b0;
         end
         // Output register.
         if (push_mid || cmd.flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         cur_row_ff   <= req_row;
         cur_col_ff   <= req_screen_col;
         inv_ff       <= req_inverse;
         show_ff      <= req_show_space;
         src_col_ff   <= start_src;
         skip_goal_ff <= start_goal;
      end
      if (cmd.load_char) begin
         ch_ff      <= req_char_code;
         last_ff    <= req_is_last;
         tab_ff     <= (req_char_code == CH_TAB);
         ctl_ff     <= (req_char_code != CH_TAB)
                       && ((req_char_code < CH_SPACE) || (req_char_code == CH_DEL));
         rem_ff     <= '0;
         mod_cnt_ff <= MODC_W'(SRC_W - 1);
      end
      if (cmd.mod_step) begin
         rem_ff     <= rem_next;
         mod_cnt_ff <= mod_cnt_ff - MODC_W'(1);
      end
      if (cmd.skip_apply) begin
         src_col_ff <= skip_sum[SRC_W-1:0];
      end
      if (cmd.seq_begin) begin
         src_col_ff <= skip_sum[SRC_W-1:0];
         k_ff       <= '0;
         m_ff       <= adv;
      end
      // Latch the cell about to be compared; the final cell may become '!'.
      if (cmd.rd_issue) begin
         cell_broke_ff <= broke_now;
         if (broke_now && !(last_ff && !tab_ff && !ctl_ff)) begin
            cell_ch_ff <= CH_BANG;
         end else begin
            cell_ch_ff <= seq_ch;
         end
      end
      if (cmd.cell_put) begin
         cur_col_ff <= cur_col_ff + COL_W'(1);
         k_ff       <= k_ff + CNT_W'(1);
         if (emit) begin
            hold_row_ff  <= cur_row_ff;
            hold_col_ff  <= cur_col_ff;
            hold_char_ff <= cell_ch_ff;
            hold_move_ff <= move;
         end
      end
      if (push_mid || cmd.flush) begin
         rsp_row_ff  <= hold_row_ff;
         rsp_col_ff  <= hold_col_ff;
         rsp_char_ff <= hold_char_ff;
         rsp_move_ff <= hold_move_ff;
         rsp_last_ff <= cmd.flush;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_char   = rsp_char_ff;
   assign rsp_move   = rsp_move_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> sv/text_line_cell_renderer_top.sv
// Text line cell renderer, top level. After reset a clearing pass fills the
// cell memory with spaces; no request is taken until it ends.
// A start request is taken in idle. A character is loaded and decided, then each
// screen cell is read, compared and written in the single cell memory, and the
// final cell is released; a tab first steps the bit-serial tab stop remainder.
// Reset is synchronous and active high; registers read tab width 8, 80 cells.
module text_line_cell_renderer_top
   import tlcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // row[4:0], screen_col[11:5], skip_cols[23:12],
                                             // text_mode[24], inverse[25], show_space[26],
                                             // char_code[34:27], zeros[39:35]
   input  logic                  req_tuser,  // func: 0 start, 1 character
   input  logic                  req_tlast,  // is_last
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // cell_row[4:0], cell_col[11:5],
                                             // cell_char[19:12], zeros[23:20]
   output logic                  rsp_tuser,  // move_first
   output logic                  rsp_tlast,  // run_last
   // Configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type      cmd;
   dp_status_type     st;
   logic [ROW_W-1:0]  rsp_row;
   logic [COL_W-1:0]  rsp_col;
   logic [CELL_W-1:0] rsp_char;

   tlcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   tlcr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_row        (req_tdata[4:0]),
      .req_screen_col (req_tdata[11:5]),
      .req_skip_cols  (req_tdata[23:12]),
      .req_text_mode  (req_tdata[24]),
      .req_inverse    (req_tdata[25]),
      .req_show_space (req_tdata[26]),
      .req_char_code  (req_tdata[34:27]),
      .req_is_last    (req_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index_type'(csr_index)),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .st             (st),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_row        (rsp_row),
      .rsp_col        (rsp_col),
      .rsp_char       (rsp_char),
      .rsp_move       (rsp_tuser),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, rsp_char, rsp_col, rsp_row};

   // A shown cell never displaces the pending one unless the output can take it.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.cell_put && st.emit && st.hold_valid) |-> st.out_free)
      else $error("pending cell overwritten while output is full");

   // A cell that is not the last of its request always has a later cell pending.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> st.hold_valid)
      else $error("non-final result without a pending follower");

   // Characters are only expanded while a line write is open.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_char |-> !st.line_done)
      else $error("character expanded after the line was done");

endmodule
